[src/sle_pkg.sv]
// Shared types and constants for the serial line editor.
// Used by every module of the block except sle_ram; depends on nothing.
`default_nettype none
package sle_pkg;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  localparam logic [1:0] REG_LINE_LIMIT    = 2'd0;
  localparam logic [1:0] REG_PROMPT_TEXT   = 2'd1;
  localparam logic [1:0] REG_PROMPT_LENGTH = 2'd2;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NAK    = 8'h15;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic [6:0]  LIMIT_RESET  = 7'd99;
  localparam logic [63:0] PROMPT_RESET = 64'h203E_6C69_636E_6570;
  localparam logic [3:0]  PLEN_RESET   = 4'd8;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [2:0] {
    E_NONE,
    E_LF,
    E_BS,
    E_KILL,
    E_ESC,
    E_DEL,
    E_CHAR,
    E_READ
  } edit_t;

  typedef struct packed {
    logic       prompt;
    edit_t      kind;
    logic [7:0] data;
    logic [6:0] count;
    logic       hit;
  } job_t;

  typedef struct packed {
    logic [6:0]  line_limit;
    logic [63:0] prompt_text;
    logic [3:0]  plen;
  } cfg_t;

  function automatic logic [2:0] edit_count(edit_t kind, logic [6:0] count);
    logic [2:0] n;
    unique case (kind)
      E_LF:   n = 3'd2;
      E_BS:   n = 3'd3;
      E_KILL: n = (count != 7'd0) ? 3'd1 : 3'd0;
      E_ESC:  n = 3'd4;
      E_DEL:  n = 3'd1;
      E_CHAR: n = 3'd1;
      E_READ: n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[src/sle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package.
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/sle_front.sv]
// Front end: accepts items, edits the line state and store, and builds jobs.
// Depends on sle_pkg and sle_ram.
`default_nettype none
module sle_front #(
  parameter int LINE_CAPACITY = 128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sle_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic [6:0]    in_read_index,
  output logic               push,
  output sle_pkg::job_t      push_job,
  input  wire logic          q_full
);
  import sle_pkg::*;

  localparam int AW      = $clog2(LINE_CAPACITY);
  localparam int CAP_LIM = (LINE_CAPACITY < 127) ? LINE_CAPACITY : 127;

  logic       accept;
  logic [6:0] fill_r, fill_nxt;
  logic       pend_r, pend_nxt;
  logic [6:0] fill_base;
  logic [6:0] room;
  logic       we;
  logic [7:0] rdata;
  logic       has_result;
  job_t       job;
  logic       f_valid_r, f_valid_nxt;
  job_t       f_job_r;

  assign in_stall  = f_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_valid_r && !q_full;
  assign fill_base = pend_r ? 7'd0 : fill_r;
  assign room      = (cfg.line_limit < 7'(CAP_LIM)) ? cfg.line_limit : 7'(CAP_LIM);

  always_comb begin
    fill_nxt   = fill_r;
    pend_nxt   = pend_r;
    we         = 1'b0;
    job.prompt = 1'b0;
    job.kind   = E_NONE;
    job.data   = in_rx_byte;
    job.count  = 7'd0;
    job.hit    = 1'b0;
    if (accept) begin
      if (in_op == OP_READ) begin
        job.kind = E_READ;
        job.hit  = in_read_index < fill_r;
      end else begin
        job.prompt = pend_r;
        pend_nxt   = 1'b0;
        fill_nxt   = fill_base;
        if (in_op == OP_BYTE) begin
          unique case (in_rx_byte)
            CH_CR: begin
              job.kind = E_NONE;
            end
            CH_LF: begin
              job.kind  = E_LF;
              job.count = fill_base;
              pend_nxt  = 1'b1;
            end
            CH_BS: begin
              job.kind = E_BS;
              fill_nxt = (fill_base == 7'd0) ? 7'd0 : fill_base - 7'd1;
            end
            CH_NAK: begin
              job.kind  = E_KILL;
              job.count = fill_base;
              fill_nxt  = 7'd0;
            end
            CH_ESC: begin
              job.kind = E_ESC;
              fill_nxt = 7'd0;
              pend_nxt = 1'b1;
            end
            CH_DEL: begin
              job.kind = E_DEL;
              fill_nxt = (fill_base == 7'd0) ? 7'd0 : fill_base - 7'd1;
            end
            default: begin
              job.kind = E_CHAR;
              if (in_rx_byte >= CH_SP && in_rx_byte < CH_DEL && fill_base < room) begin
                we       = 1'b1;
                fill_nxt = fill_base + 7'd1;
              end
            end
          endcase
        end
      end
    end
  end

  assign has_result = (job.prompt && cfg.plen != 4'd0) ||
                      (edit_count(job.kind, job.count) != 3'd0);

  sle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAPACITY)
  ) u_line_store (
    .clk  (clk),
    .we   (we),
    .waddr(AW'(fill_base)),
    .wdata(in_rx_byte),
    .re   (accept),
    .raddr(AW'(in_read_index)),
    .rdata(rdata)
  );

  always_comb begin
    if (accept) begin
      f_valid_nxt = has_result;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= 7'd0;
      pend_r    <= 1'b1;
      f_valid_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      pend_r    <= pend_nxt;
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_job_r <= job;
    end
  end

  always_comb begin
    push_job = f_job_r;
    if (f_job_r.kind == E_READ) begin
      push_job.data = f_job_r.hit ? rdata : 8'd0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 7'(CAP_LIM))
    else $error("line fill beyond capacity");

  a_lf_owes_prompt: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_BYTE && in_rx_byte == CH_LF |=> pend_r)
    else $error("prompt not owed after line end");

endmodule
`default_nettype wire

[src/sle_queue.sv]
// Short job queue between the front and back ends.
// Depends on sle_pkg.
`default_nettype none
module sle_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sle_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output sle_pkg::job_t      q_job
);
  import sle_pkg::*;

  job_t             slot_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full    = cnt_r == (QAW+1)'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_job   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop) && cnt_r <= (QAW+1)'(QDEPTH))
    else $error("job queue overflow");

endmodule
`default_nettype wire

[src/sle_back.sv]
// Back end: expands each job into its result items, one per cycle while the output is not stalled.
// Depends on sle_pkg.
`default_nettype none
module sle_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sle_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire sle_pkg::job_t q_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_echo_byte,
  output logic [6:0]         out_erase_count,
  output logic               out_line_done,
  output logic [6:0]         out_line_length,
  output logic [7:0]         out_read_char,
  output logic               out_last
);
  import sle_pkg::*;

  logic [3:0] k_r, k_nxt;
  logic [3:0] pcnt;
  logic [3:0] total;
  logic [1:0] e;
  logic       load;
  logic       last;
  logic [7:0] echo;
  logic [6:0] erase;
  logic       done;
  logic [6:0] len;
  logic [7:0] rchar;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] echo_r;
  logic [6:0] erase_r;
  logic       done_r;
  logic [6:0] len_r;
  logic [7:0] rchar_r;
  logic       last_r;

  assign pcnt  = q_job.prompt ? cfg.plen : 4'd0;
  assign total = pcnt + {1'b0, edit_count(q_job.kind, q_job.count)};
  assign e     = 2'(k_r - pcnt);
  assign last  = k_r == total - 4'd1;
  assign load  = q_valid && (!out_valid_r || !out_stall);
  assign pop   = load && last;

  always_comb begin
    echo  = 8'd0;
    erase = 7'd0;
    done  = 1'b0;
    len   = 7'd0;
    rchar = 8'd0;
    if (k_r < pcnt) begin
      echo = cfg.prompt_text[{k_r[2:0], 3'b000} +: 8];
    end else begin
      unique case (q_job.kind)
        E_LF: begin
          echo = (e == 2'd0) ? CH_CR : CH_LF;
          if (e != 2'd0) begin
            done = 1'b1;
            len  = q_job.count;
          end
        end
        E_BS: begin
          echo = (e == 2'd1) ? CH_SP : CH_BS;
        end
        E_KILL: begin
          erase = q_job.count;
        end
        E_ESC: begin
          case (e)
            2'd0:    echo = CH_CARET;
            2'd1:    echo = CH_LBRACK;
            2'd2:    echo = CH_CR;
            default: echo = CH_LF;
          endcase
        end
        E_DEL: begin
          echo = CH_DEL;
        end
        E_CHAR: begin
          echo = q_job.data;
        end
        E_READ: begin
          rchar = q_job.data;
        end
        default: begin
          echo = 8'd0;
        end
      endcase
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (load) begin
      k_nxt = last ? 4'd0 : k_r + 4'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      echo_r  <= echo;
      erase_r <= erase;
      done_r  <= done;
      len_r   <= len;
      rchar_r <= rchar;
      last_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_byte   = echo_r;
  assign out_erase_count = erase_r;
  assign out_line_done   = done_r;
  assign out_line_length = len_r;
  assign out_read_char   = rchar_r;
  assign out_last        = last_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (total != 4'd0 && k_r < total))
    else $error("result step outside job");

endmodule
`default_nettype wire

[src/serial_line_editor.sv]
// Serial line editor top level: configuration registers, front end, job
// queue and back end. Depends on sle_pkg, sle_front, sle_queue, sle_back.
//
//   port group  direction  handshake           payload
//   in_*        in         in_valid/in_stall   op, rx_byte, read_index
//   out_*       out        out_valid/out_stall echo_byte, erase_count,
//                                              line_done, line_length,
//                                              read_char, last
//   cfg_*       in         cfg_we              cfg_index, cfg_wdata
//
// The front end takes one item per cycle while the job queue has room.
// The back end sends one result per cycle while the output is not stalled;
// an item has 1 to 12 results, and items without results never reach it.
// An accepted item passes the front-end job register and the job queue.
// Reset: line empty, prompt owed; no clearing pass over the line store.
// A stalled output holds; the queue keeps accepting until it fills.
`default_nettype none
module serial_line_editor #(
  parameter int LINE_CAPACITY = 128,
  parameter int PROMPT_MAX    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [6:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_echo_byte,
  output logic [6:0]       out_erase_count,
  output logic             out_line_done,
  output logic [6:0]       out_line_length,
  output logic [7:0]       out_read_char,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  import sle_pkg::*;

  logic [6:0]  limit_r;
  logic [63:0] ptext_r;
  logic [3:0]  plength_r;
  cfg_t        cfg;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        q_valid;
  job_t        q_job;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RESET;
      ptext_r   <= PROMPT_RESET;
      plength_r <= PLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_LIMIT:    limit_r   <= cfg_wdata[6:0];
        REG_PROMPT_TEXT:   ptext_r   <= cfg_wdata;
        REG_PROMPT_LENGTH: plength_r <= cfg_wdata[3:0];
        default:           limit_r   <= limit_r;
      endcase
    end
  end

  always_comb begin
    cfg.line_limit  = limit_r;
    cfg.prompt_text = ptext_r;
    cfg.plen        = (plength_r > 4'(PROMPT_MAX)) ? 4'(PROMPT_MAX) : plength_r;
  end

  sle_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_rx_byte   (in_rx_byte),
    .in_read_index(in_read_index),
    .push         (push),
    .push_job     (push_job),
    .q_full       (q_full)
  );

  sle_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  sle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_echo_byte  (out_echo_byte),
    .out_erase_count(out_erase_count),
    .out_line_done  (out_line_done),
    .out_line_length(out_line_length),
    .out_read_char  (out_read_char),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

[sim/sle_line_checker.sv]
`timescale 1ns / 1ps
// Result checker for the serial line editor: watches the item, result and register ports,
// predicts every result from its own copy of the line state, and counts mismatches.
// Depends on sle_pkg only.
module sle_line_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic [6:0]  in_read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_echo_byte,
  input  logic [6:0]  out_erase_count,
  input  logic        out_line_done,
  input  logic [6:0]  out_line_length,
  input  logic [7:0]  out_read_char,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        drain_done,
  output int          awaited,
  output int          fail_count
);
  import sle_pkg::*;

  localparam int PROMPT_CHARS = 8;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [7:0] echo;
    logic [6:0] erase;
    logic       done;
    logic [6:0] length;
    logic [7:0] char_read;
    logic       last;
  } echo_result_t;

  echo_result_t echo_queue[$];
  logic [7:0]   line_chars [0:127];
  logic [6:0]   line_fill;
  logic         prompt_owed;
  cfg_t         regs;
  int           result_index;
  logic         drained;

  initial begin
    fail_count = 0;
    awaited    = 0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic push_result(input logic [7:0] echo, input logic [6:0] erase,
                             input logic done, input logic [6:0] length,
                             input logic [7:0] char_read);
    echo_result_t r;
    r.echo      = echo;
    r.erase     = erase;
    r.done      = done;
    r.length    = length;
    r.char_read = char_read;
    r.last      = 1'b0;
    echo_queue.push_back(r);
  endtask

  task automatic apply_byte(input logic [7:0] b);
    case (b)
      CH_CR: ;
      CH_LF: begin
        push_result(CH_CR, 7'd0, 1'b0, 7'd0, 8'h00);
        push_result(CH_LF, 7'd0, 1'b1, line_fill, 8'h00);
        prompt_owed = 1'b1;
      end
      CH_BS: begin
        if (line_fill != 7'd0) line_fill--;
        push_result(CH_BS, 7'd0, 1'b0, 7'd0, 8'h00);
        push_result(CH_SP, 7'd0, 1'b0, 7'd0, 8'h00);
        push_result(CH_BS, 7'd0, 1'b0, 7'd0, 8'h00);
      end
      CH_NAK: begin
        if (line_fill != 7'd0) push_result(8'h00, line_fill, 1'b0, 7'd0, 8'h00);
        line_fill = 7'd0;
      end
      CH_ESC: begin
        push_result(CH_CARET, 7'd0, 1'b0, 7'd0, 8'h00);
        push_result(CH_LBRACK, 7'd0, 1'b0, 7'd0, 8'h00);
        push_result(CH_CR, 7'd0, 1'b0, 7'd0, 8'h00);
        push_result(CH_LF, 7'd0, 1'b0, 7'd0, 8'h00);
        line_fill   = 7'd0;
        prompt_owed = 1'b1;
      end
      CH_DEL: begin
        if (line_fill != 7'd0) line_fill--;
        push_result(CH_DEL, 7'd0, 1'b0, 7'd0, 8'h00);
      end
      default: begin
        if (b >= CH_SP && b < CH_DEL && line_fill < regs.line_limit) begin
          line_chars[line_fill] = b;
          line_fill++;
        end
        push_result(b, 7'd0, 1'b0, 7'd0, 8'h00);
      end
    endcase
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [7:0] b,
                              input logic [6:0] idx);
    int first;
    int count;
    int i;
    echo_result_t tail;
    first = echo_queue.size();
    if (op == OP_READ) begin
      push_result(8'h00, 7'd0, 1'b0, 7'd0, (idx < line_fill) ? line_chars[idx] : 8'h00);
    end else begin
      if (prompt_owed) begin
        count = (regs.plen > PROMPT_CHARS) ? PROMPT_CHARS : int'(regs.plen);
        line_fill = 7'd0;
        for (i = 0; i < count; i++)
          push_result(regs.prompt_text[8*i +: 8], 7'd0, 1'b0, 7'd0, 8'h00);
        prompt_owed = 1'b0;
      end
      if (op == OP_BYTE) apply_byte(b);
    end
    if (echo_queue.size() > first) begin
      tail = echo_queue.pop_back();
      tail.last = 1'b1;
      echo_queue.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    echo_result_t got;
    echo_result_t want;
    if (!rst_n) begin
      echo_queue.delete();
      line_fill        = 7'd0;
      prompt_owed      = 1'b1;
      regs.line_limit  = LIMIT_RESET;
      regs.prompt_text = PROMPT_RESET;
      regs.plen        = PLEN_RESET;
      result_index     = 0;
      drained          = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.echo      = out_echo_byte;
        got.erase     = out_erase_count;
        got.done      = out_line_done;
        got.length    = out_line_length;
        got.char_read = out_read_char;
        got.last      = out_last;
        if (echo_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected (echo %h last %b)",
                                    result_index, got.echo, got.last));
        end else begin
          want = echo_queue.pop_front();
          if (got !== want)
            report_mismatch($sformatf({"result %0d got/want echo %h/%h erase %0d/%0d ",
                                       "done %b/%b length %0d/%0d char %h/%h last %b/%b"},
                                      result_index, got.echo, want.echo, got.erase,
                                      want.erase, got.done, want.done, got.length,
                                      want.length, got.char_read, want.char_read,
                                      got.last, want.last));
        end
        result_index++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_LIMIT:    regs.line_limit  = cfg_wdata[6:0];
          REG_PROMPT_TEXT:   regs.prompt_text = cfg_wdata;
          REG_PROMPT_LENGTH: regs.plen        = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(in_op, in_rx_byte, in_read_index);
      if (drain_done && !drained) begin
        drained = 1'b1;
        while (echo_queue.size() != 0) begin
          want = echo_queue.pop_front();
          report_mismatch($sformatf("result %0d never arrived (echo %h last %b)",
                                    result_index, want.echo, want.last));
          result_index++;
        end
      end
    end
    awaited = echo_queue.size();
  end

endmodule

[sim/serial_line_editor_test.sv]
`timescale 1ns / 1ps
// Testbench top for the serial line editor: clock, reset, register setup, item stimulus,
// random stalls and the verdict. Depends on sle_pkg, serial_line_editor and sle_line_checker.
module serial_line_editor_test;
  import sle_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  wire logic   in_stall;
  logic [1:0]  in_op;
  logic [7:0]  in_rx_byte;
  logic [6:0]  in_read_index;
  wire logic   out_valid;
  logic        out_stall;
  wire logic [7:0] out_echo_byte;
  wire logic [6:0] out_erase_count;
  wire logic   out_line_done;
  wire logic [6:0] out_line_length;
  wire logic [7:0] out_read_char;
  wire logic   out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        drain_done;
  int          awaited;
  int          fail_count;
  logic        sender_gaps;
  logic        receiver_gaps;
  logic        hold_req;
  int          items_sent;
  int          quiet_cycles = 0;

  serial_line_editor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_rx_byte(in_rx_byte),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_echo_byte(out_echo_byte),
    .out_erase_count(out_erase_count), .out_line_done(out_line_done),
    .out_line_length(out_line_length), .out_read_char(out_read_char), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sle_line_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_rx_byte(in_rx_byte),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_echo_byte(out_echo_byte),
    .out_erase_count(out_erase_count), .out_line_done(out_line_done),
    .out_line_length(out_line_length), .out_read_char(out_read_char), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .drain_done(drain_done), .awaited(awaited), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= receiver_gaps && ($urandom_range(99) < 19);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic [6:0] idx);
    @(negedge clk);
    while (sender_gaps && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_rx_byte    <= b;
    in_read_index <= idx;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b, 7'($urandom_range(127)));
  endtask

  task automatic send_read(input logic [6:0] idx);
    send_item(OP_READ, 8'($urandom_range(255)), idx);
  endtask

  task automatic send_poll();
    send_item(($urandom_range(1) == 0) ? OP_POLL : OP_SPARE, 8'($urandom_range(255)),
              7'($urandom_range(127)));
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(CH_DEL - 1, CH_SP));
  endfunction

  // hold until every expected result is back and zero-result items have drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [6:0] limit, input logic [63:0] text,
                           input logic [3:0] plen);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_LIMIT;
    cfg_wdata <= {57'd0, limit};
    @(negedge clk);
    cfg_index <= REG_PROMPT_TEXT;
    cfg_wdata <= text;
    @(negedge clk);
    cfg_index <= REG_PROMPT_LENGTH;
    cfg_wdata <= {60'd0, plen};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed lines with random edits, some broken or noisy
  task automatic random_lines(input int quota, input int max_len);
    int stop;
    int len;
    int pick;
    int k;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      if ($urandom_range(9) == 0) send_poll();
      len = $urandom_range(max_len);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        if (pick < 68) send_byte(printable());
        else if (pick < 74) send_byte(CH_BS);
        else if (pick < 78) send_byte(CH_DEL);
        else if (pick < 84)
          send_read(($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                              : 7'($urandom_range(max_len + 1)));
        else if (pick < 86) send_byte(CH_NAK);
        else if (pick < 89) send_byte(CH_CR);
        else if (pick < 94) send_byte(8'($urandom_range(255)));
        else send_poll();
      end
      pick = $urandom_range(99);
      if (pick < 84) send_byte(CH_LF);
      else if (pick < 92) send_byte(CH_ESC);
      if ($urandom_range(3) == 0) send_read(7'($urandom_range(max_len + 1)));
    end
  endtask

  initial begin
    in_valid      = 1'b0;
    in_op         = OP_POLL;
    in_rx_byte    = 8'h00;
    in_read_index = 7'd0;
    cfg_we        = 1'b0;
    cfg_index     = REG_LINE_LIMIT;
    cfg_wdata     = 64'd0;
    drain_done    = 1'b0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    hold_req      = 1'b0;
    items_sent    = 0;
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_poll();
    send_item(OP_SPARE, 8'h00, 7'd0);
    send_byte(8'h41);
    send_byte(CH_SP);
    send_byte(8'h7E);
    send_read(7'd0);
    send_read(7'd2);
    send_read(7'd3);
    send_read(7'd127);
    send_byte(CH_CR);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    send_byte(CH_NAK);
    send_byte(CH_NAK);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h78);
    send_byte(CH_LF);
    send_read(7'd0);
    send_item(OP_SPARE, 8'hFF, 7'd127);
    send_byte(CH_ESC);
    send_byte(8'h5A);

    configure(7'd0, {$urandom, $urandom}, 4'd0);
    random_lines(50, 6);

    configure(7'd127, '1, 4'd15);
    send_poll();
    repeat (135) send_byte(printable());
    send_read(7'd126);
    send_read(7'd127);
    send_byte(CH_LF);
    random_lines(20, 30);

    configure(7'd1, 64'd0, PLEN_RESET);
    random_lines(50, 4);

    configure(7'($urandom_range(20, 2)), {$urandom, $urandom}, 4'($urandom_range(15)));
    hold_req = 1'b1;
    random_lines(60, 12);

    configure(7'($urandom_range(127, 1)), {$urandom, $urandom}, 4'($urandom_range(15)));
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    random_lines(60, 10);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;

    configure(LIMIT_RESET, PROMPT_RESET, PLEN_RESET);
    random_lines(40, 16);

    settle();
    drain_done <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
